// ----- design/chained_hash_set_core_defines.svh -----
// Assertion macros for the hash set core.
`ifndef CHAINED_HASH_SET_CORE_DEFINES_SVH
`define CHAINED_HASH_SET_CORE_DEFINES_SVH

`define CHS_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`define CHS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- design/chs_pkg.sv -----
package chs_pkg;

    localparam int NUM_BUCKETS_DEF  = 64;
    localparam int BUCKET_DEPTH_DEF = 8;
    localparam int KEY_W            = 32;
    localparam int CNT_W            = 10;
    localparam int BKT_W            = 6;
    localparam int BCFG_W           = 7;

    localparam logic [2:0] ADDR_BUCKET_COUNT = 3'd0;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic signed [31:0] key;
        logic [5:0]        bucket_index;
    } request_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [5:0] hashed_bucket;
        logic [9:0] element_count;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch request, start divider
        logic div_step;
        logic rd_fill;   // capture bucket fill
        logic rd_entry;  // issue read of scan pointer
        logic cmp;       // compare returned entry, advance pointer on a miss
        logic wr_insert;
        logic shift_rd;  // read entry ptr+1
        logic shift_wr;  // write entry ptr
        logic commit;    // update fill/total and emit
        logic wipe_start;
        logic wipe_step;
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic is_clear;
        logic scan_end;
        logic hit;
        logic op_insert;
        logic op_remove;
        logic shift_end;
        logic wipe_end;
    } stat_t;

endpackage

// ----- design/chs_ctrl.sv -----
module chs_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           wipe_req,
    input  chs_pkg::stat_t st,
    output chs_pkg::ctrl_t ctl,
    output logic           busy
);

    typedef enum logic [3:0] {
        S_IDLE, S_WIPE, S_DIV, S_FILL, S_RD, S_WAIT, S_CMP, S_INS, S_SRD, S_SWAIT,
        S_SWR, S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (wipe_req)
                begin
                    ctl.wipe_start = 1'b1;
                    state_next = S_WIPE;
                end
                else if (start)
                begin
                    ctl.load = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_WIPE:
            begin
                ctl.wipe_step = 1'b1;
                if (st.wipe_end)
                    state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (st.is_clear)
                    state_next = S_FILL;
                else if (st.div_done)
                    state_next = S_FILL;
                else
                    ctl.div_step = 1'b1;
            end
            S_FILL:
            begin
                ctl.rd_fill = 1'b1;
                state_next = st.is_clear ? S_DONE : S_RD;
            end
            S_RD:
            begin
                if (st.scan_end)
                    state_next = S_INS;
                else
                begin
                    ctl.rd_entry = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:  state_next = S_CMP;
            S_CMP:
            begin
                ctl.cmp = 1'b1;
                state_next = st.hit ? S_INS : S_RD;
            end
            S_INS:
            begin
                if (st.op_insert)
                begin
                    ctl.wr_insert = 1'b1;
                    state_next = S_DONE;
                end
                else if (st.op_remove && st.hit)
                    state_next = S_SRD;
                else
                    state_next = S_DONE;
            end
            S_SRD:
            begin
                if (st.shift_end)
                    state_next = S_DONE;
                else
                begin
                    ctl.shift_rd = 1'b1;
                    state_next = S_SWAIT;
                end
            end
            S_SWAIT: state_next = S_SWR;
            S_SWR:
            begin
                ctl.shift_wr = 1'b1;
                state_next = S_SRD;
            end
            S_DONE:
            begin
                ctl.commit = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_WIPE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE) || wipe_req;

endmodule

// ----- design/chs_dp.sv -----
module chs_dp
#(
    parameter int NUM_BUCKETS  = chs_pkg::NUM_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = chs_pkg::BUCKET_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  chs_pkg::request_t req,
    input  logic [6:0]        bucket_count,
    input  chs_pkg::ctrl_t    ctl,
    output chs_pkg::stat_t    st,
    output logic              done,
    output chs_pkg::result_t  result
);

    localparam int BW   = $clog2(NUM_BUCKETS);
    localparam int DW   = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FW   = $clog2(BUCKET_DEPTH + 1);
    localparam int AW   = BW + DW;
    localparam int TW   = $clog2(NUM_BUCKETS * BUCKET_DEPTH + 1);

    logic [31:0]   keys [0:(1 << AW) - 1];
    logic [FW-1:0] fills [0:NUM_BUCKETS - 1];

    logic [1:0]    op_reg;
    logic [31:0]   key_reg;
    logic [5:0]    idx_reg;
    logic [31:0]   quo_reg;
    logic [6:0]    rem_reg;
    logic [5:0]    dcnt_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] ptr_reg;
    logic          hit_reg;
    logic [31:0]   rdata_reg;
    logic [TW-1:0] total_reg;
    logic [BW:0]   wptr_reg;
    logic          done_reg;
    logic [1:0]    status_reg;
    logic          found_reg;
    logic [5:0]    hbkt_reg;

    logic [7:0]    rem_sh;
    logic [6:0]    rem_sub;
    logic [BW-1:0] bkt;
    logic          clr_ok;
    logic [DW-1:0] ptr_idx;
    logic [DW-1:0] ptr1_idx;

    assign rem_sh  = {rem_reg, quo_reg[31]};
    assign rem_sub = (rem_sh >= {1'b0, bucket_count}) ? 7'(rem_sh - {1'b0, bucket_count})
                                                      : rem_sh[6:0];
    assign bkt     = (op_reg == chs_pkg::OP_CLEAR) ? BW'(idx_reg) : BW'(rem_reg);
    assign clr_ok  = ({1'b0, idx_reg} < bucket_count) && (32'(idx_reg) < NUM_BUCKETS);
    assign ptr_idx  = DW'(ptr_reg);
    assign ptr1_idx = DW'(ptr_reg + FW'(1));

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg   <= req.opcode;
            key_reg  <= req.key;
            idx_reg  <= req.bucket_index;
            quo_reg  <= req.key[31] ? 32'(-req.key) : req.key;
            rem_reg  <= '0;
            dcnt_reg <= '0;
            hit_reg  <= 1'b0;
            ptr_reg  <= '0;
        end
        if (ctl.div_step)
        begin
            quo_reg  <= {quo_reg[30:0], 1'b0};
            rem_reg  <= rem_sub;
            dcnt_reg <= dcnt_reg + 6'd1;
        end
        if (ctl.rd_fill)
            fill_reg <= fills[bkt];
        if (ctl.rd_entry)
            rdata_reg <= keys[{bkt, ptr_idx}];
        if (ctl.cmp)
        begin
            if (rdata_reg == key_reg)
                hit_reg <= 1'b1;
            else
                ptr_reg <= ptr_reg + FW'(1);
        end
        if (ctl.wr_insert && fill_reg < FW'(BUCKET_DEPTH))
            keys[{bkt, DW'(fill_reg)}] <= key_reg;
        if (ctl.shift_rd)
            rdata_reg <= keys[{bkt, ptr1_idx}];
        if (ctl.shift_wr)
        begin
            keys[{bkt, ptr_idx}] <= rdata_reg;
            ptr_reg <= ptr_reg + FW'(1);
        end
        if (ctl.wipe_step)
            fills[wptr_reg[BW-1:0]] <= '0;
        if (ctl.commit)
        begin
            found_reg  <= hit_reg && (op_reg != chs_pkg::OP_CLEAR);
            hbkt_reg   <= (op_reg == chs_pkg::OP_CLEAR) ? idx_reg : 6'(rem_reg);
            status_reg <= chs_pkg::ST_OK;
            unique case (op_reg)
                chs_pkg::OP_CLEAR:
                begin
                    if (clr_ok)
                        fills[bkt] <= '0;
                    else
                        status_reg <= chs_pkg::ST_RANGE;
                end
                chs_pkg::OP_INSERT:
                begin
                    if (fill_reg >= FW'(BUCKET_DEPTH))
                        status_reg <= chs_pkg::ST_FULL;
                    else
                        fills[bkt] <= fill_reg + FW'(1);
                end
                chs_pkg::OP_FIND:
                begin
                    if (!hit_reg)
                        status_reg <= chs_pkg::ST_NOT_FOUND;
                end
                default:
                begin
                    if (!hit_reg)
                        status_reg <= chs_pkg::ST_NOT_FOUND;
                    else
                        fills[bkt] <= fill_reg - FW'(1);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            wptr_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.commit;
            if (ctl.wipe_start)
            begin
                wptr_reg  <= '0;
                total_reg <= '0;
            end
            if (ctl.wipe_step)
                wptr_reg <= wptr_reg + 1'b1;
            if (ctl.commit)
            begin
                unique case (op_reg)
                    chs_pkg::OP_CLEAR:
                    begin
                        if (clr_ok)
                            total_reg <= total_reg - TW'(fill_reg);
                    end
                    chs_pkg::OP_INSERT:
                    begin
                        if (fill_reg < FW'(BUCKET_DEPTH))
                            total_reg <= total_reg + TW'(1);
                    end
                    chs_pkg::OP_REMOVE:
                    begin
                        if (hit_reg)
                            total_reg <= total_reg - TW'(1);
                    end
                    default: total_reg <= total_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        result.status        = status_reg;
        result.found         = found_reg;
        result.hashed_bucket = hbkt_reg;
        result.element_count = 10'(total_reg);
    end

    assign done        = done_reg;
    assign st.div_done = (dcnt_reg == 6'd32);
    assign st.is_clear = (op_reg == chs_pkg::OP_CLEAR);
    assign st.scan_end = (ptr_reg >= fill_reg);
    assign st.hit      = (rdata_reg == key_reg);
    assign st.op_insert = (op_reg == chs_pkg::OP_INSERT);
    assign st.op_remove = (op_reg == chs_pkg::OP_REMOVE);
    assign st.shift_end = ((ptr_reg + FW'(1)) >= fill_reg);
    assign st.wipe_end  = (wptr_reg == (BW + 1)'(NUM_BUCKETS - 1));

endmodule

// ----- design/chained_hash_set_core.sv -----
// Hash multiset with per-bucket chains. A request is taken when start is high
// and busy is low, and the next one only when busy is low again. A request runs
// the bit-serial modulo (one quotient bit per cycle), reads and compares each
// bucket entry scanned and, on remove, reads and writes each entry moved up,
// with control states around these steps; a clear bucket request skips the
// modulo and the scan. result_valid pulses for one cycle; it is registered from
// the commit state, the request's last state. The receiver cannot stall it. A
// clearing pass over all NUM_BUCKETS fill counters keeps busy high after reset
// and after each bucket_count write.
module chained_hash_set_core
#(
    parameter int NUM_BUCKETS  = chs_pkg::NUM_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = chs_pkg::BUCKET_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  chs_pkg::request_t request,
    output logic              result_valid,
    output chs_pkg::result_t  result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [6:0]     bcount_reg;
    logic           wipe_reg;
    logic           cfg_wr;
    logic           cfg_sel;
    logic [6:0]     wv;
    chs_pkg::ctrl_t ctl;
    chs_pkg::stat_t st;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == chs_pkg::ADDR_BUCKET_COUNT[2]);
    assign cfg_wr  = psel && penable && pwrite && cfg_sel;
    assign wv      = pwdata[6:0];
    assign prdata  = cfg_sel ? {25'd0, bcount_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg <= (NUM_BUCKETS >= 64) ? 7'd64 : 7'(NUM_BUCKETS);
            wipe_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.wipe_start)
                wipe_reg <= 1'b0;
            if (cfg_wr)
            begin
                wipe_reg <= 1'b1;
                if (wv == 7'd0)
                    bcount_reg <= 7'd1;
                else if (32'(wv) > NUM_BUCKETS)
                    bcount_reg <= 7'(NUM_BUCKETS);
                else
                    bcount_reg <= wv;
            end
        end
    end

    chs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .wipe_req (wipe_reg),
        .st       (st),
        .ctl      (ctl),
        .busy     (busy)
    );

    chs_dp #(.NUM_BUCKETS(NUM_BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (request),
        .bucket_count (bcount_reg),
        .ctl          (ctl),
        .st           (st),
        .done         (result_valid),
        .result       (result)
    );

endmodule

// ----- design/chs_checker.sv -----
`include "chained_hash_set_core_defines.svh"

module chs_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             result_valid,
    input chs_pkg::result_t result
);

    `CHS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `CHS_ASSERT_IMPL(a_single_pulse, clk, rst_n, result_valid, !$past(result_valid))
    `CHS_ASSERT_IMPL(a_count_range, clk, rst_n, result_valid, result.element_count <= 10'd512)
    `CHS_ASSERT_IMPL(a_found_clear, clk, rst_n,
        result_valid && result.status == chs_pkg::ST_RANGE, !result.found)

endmodule

bind chained_hash_set_core chs_checker u_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
